/* rtl/core/wae_pkg.sv */
package wae_pkg;

	// Width of every data field on the ports.
	localparam int FIELD_BITS = 64;

	// Action codes of a request.
	localparam logic [1:0] ACT_LOAD_ROW   = 2'd0;
	localparam logic [1:0] ACT_LOAD_CONST = 2'd1;
	localparam logic [1:0] ACT_ENCRYPT    = 2'd2;

	typedef struct packed {
		logic [1:0]            action;
		logic [5:0]            round_index;
		logic [6:0]            row_index;
		logic [FIELD_BITS-1:0] row_mask_x;
		logic [FIELD_BITS-1:0] row_mask_y;
		logic [FIELD_BITS-1:0] const_x;
		logic [FIELD_BITS-1:0] const_y;
		logic [FIELD_BITS-1:0] plain_x;
		logic [FIELD_BITS-1:0] plain_y;
	} cmd_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] cipher_x;
		logic [FIELD_BITS-1:0] cipher_y;
	} res_t;

	// Controls from the sequencer to the bit-serial datapath.
	typedef struct packed {
		logic load_plain;
		logic swap;
		logic load_const;
		logic row_valid;
		logic row_is_y;
		logic add_en;
	} ctl_t;

endpackage

/* rtl/core/wae_store.sv */
module wae_store #(
	parameter int WORD_BITS   = 64,
	parameter int ROUND_COUNT = 34
) (
	input  logic                                              clk,
	input  logic                                              mat_we,
	input  logic [$clog2((ROUND_COUNT+1)*2*WORD_BITS)-1:0]    mat_waddr,
	input  logic [2*WORD_BITS-1:0]                            mat_wdata,
	input  logic                                              mat_re,
	input  logic [$clog2((ROUND_COUNT+1)*2*WORD_BITS)-1:0]    mat_raddr,
	output logic [2*WORD_BITS-1:0]                            mat_rdata,
	input  logic                                              cst_we,
	input  logic [$clog2(ROUND_COUNT+1)-1:0]                  cst_waddr,
	input  logic [2*WORD_BITS-1:0]                            cst_wdata,
	input  logic                                              cst_re,
	input  logic [$clog2(ROUND_COUNT+1)-1:0]                  cst_raddr,
	output logic [2*WORD_BITS-1:0]                            cst_rdata
);

	localparam int LAYERS    = ROUND_COUNT + 1;
	localparam int MAT_DEPTH = LAYERS * 2 * WORD_BITS;

	// Each matrix row holds the y mask in the upper half and the x mask below.
	logic [2*WORD_BITS-1:0] mat_mem [MAT_DEPTH];
	logic [2*WORD_BITS-1:0] cst_mem [LAYERS];

	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= mat_wdata;
		end
		if (mat_re) begin
			mat_rdata <= mat_mem[mat_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cst_we) begin
			cst_mem[cst_waddr] <= cst_wdata;
		end
		if (cst_re) begin
			cst_rdata <= cst_mem[cst_raddr];
		end
	end

endmodule

/* rtl/core/wae_serial.sv */
module wae_serial #(
	parameter int WORD_BITS = 64
) (
	input  logic                   clk,
	input  wae_pkg::ctl_t          ctl,
	input  logic [WORD_BITS-1:0]   plain_x,
	input  logic [WORD_BITS-1:0]   plain_y,
	input  logic [2*WORD_BITS-1:0] row_data,
	input  logic [2*WORD_BITS-1:0] const_data,
	output logic [WORD_BITS-1:0]   result_x,
	output logic [WORD_BITS-1:0]   result_y
);

	logic [WORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [WORD_BITS-1:0] nx_sh_q, ny_sh_q;
	logic [WORD_BITS-1:0] cx_sh_q, cy_sh_q;
	logic                 nx_bit_q;
	logic                 carry_q;

	logic par, bit_new, sum_bit, carry_nxt;

	// One matrix row gives one output bit: the parity of the masked words.
	assign par     = ^((row_data[WORD_BITS-1:0] & cur_x_q) ^
	                   (row_data[2*WORD_BITS-1:WORD_BITS] & cur_y_q));
	assign bit_new = par ^ (ctl.row_is_y ? cy_sh_q[0] : cx_sh_q[0]);

	// Rows come as x bit r then y bit r, so the addition runs one bit at a time.
	assign sum_bit   = nx_bit_q ^ (ctl.add_en ? (bit_new ^ carry_q) : 1'b0);
	assign carry_nxt = (nx_bit_q & bit_new) | (carry_q & (nx_bit_q ^ bit_new));

	always_ff @(posedge clk) begin
		if (ctl.load_plain) begin
			cur_x_q <= plain_x;
			cur_y_q <= plain_y;
		end else if (ctl.swap) begin
			cur_x_q <= nx_sh_q;
			cur_y_q <= ny_sh_q;
		end
		if (ctl.load_const) begin
			cx_sh_q <= const_data[WORD_BITS-1:0];
			cy_sh_q <= const_data[2*WORD_BITS-1:WORD_BITS];
			carry_q <= 1'b0;
		end
		if (ctl.row_valid && !ctl.row_is_y) begin
			nx_bit_q <= bit_new;
			cx_sh_q  <= cx_sh_q >> 1;
		end
		if (ctl.row_valid && ctl.row_is_y) begin
			cy_sh_q <= cy_sh_q >> 1;
			ny_sh_q <= {bit_new, ny_sh_q[WORD_BITS-1:1]};
			nx_sh_q <= {sum_bit, nx_sh_q[WORD_BITS-1:1]};
			if (ctl.add_en) begin
				carry_q <= carry_nxt;
			end
		end
	end

	assign result_x = nx_sh_q;
	assign result_y = ny_sh_q;

endmodule

/* rtl/core/whitebox_affine_arx_encrypt.sv */
// An encrypt request holds the sequencer from acceptance until its result is loaded into the
// output register; no new request is taken before then. The single matrix read port, one row
// per cycle, sets the pace. A load is written into its store as it is accepted.
// Reset clears the sequencer and the result valid flag; the matrix and constant memories
// are not cleared and must be loaded before an encrypt uses them.
module whitebox_affine_arx_encrypt #(
	parameter int ROUND_COUNT = 34,
	parameter int WORD_BITS   = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  wae_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output wae_pkg::res_t res
);

	localparam int LAYERS = ROUND_COUNT + 1;
	localparam int ROWS   = 2 * WORD_BITS;
	localparam int AW     = $clog2(LAYERS * ROWS);
	localparam int LW     = $clog2(LAYERS);
	localparam int KW     = $clog2(ROWS);

	// The sequencer walks each affine layer: a start state that fetches the constant
	// pair, a run state that reads every matrix row of the layer in turn, and a drain
	// state for the last row in flight. Rows are read interleaved (x row r, then y
	// row r), so the datapath can add the new words bit by bit as their bits appear.
	typedef enum logic [2:0] {
		IDLE,
		START,
		RUN,
		DRAIN,
		FINISH
	} state_t;

	state_t          state_q;
	logic [LW-1:0]   layer_q;
	logic [AW-1:0]   base_q;
	logic [KW-1:0]   k_q;
	logic            rd_vld_s1;
	logic            rd_half_s1;
	logic            res_valid_q;
	wae_pkg::res_t   res_q;

	logic                 cmd_accept;
	logic                 is_encrypt;
	logic                 load_out;
	logic [KW-1:0]        row_off;
	logic                 mat_we, mat_re, cst_we, cst_re;
	logic [AW-1:0]        mat_waddr, mat_raddr;
	logic [LW-1:0]        cst_waddr;
	logic [ROWS-1:0]      mat_wdata, cst_wdata, mat_rdata, cst_rdata;
	logic                 layer_ok, row_ok;
	wae_pkg::ctl_t        ctl;
	logic [WORD_BITS-1:0] result_x, result_y;

	// A request is taken only while the sequencer is idle.
	assign cmd_stall  = (state_q != IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign is_encrypt = (cmd.action == wae_pkg::ACT_ENCRYPT);

	// Loads aimed past the last layer or past the last row are dropped.
	assign layer_ok = ({1'b0, cmd.round_index} <= 7'(ROUND_COUNT));
	assign row_ok   = ({1'b0, cmd.row_index} < 8'(ROWS));

	assign mat_we    = cmd_accept && (cmd.action == wae_pkg::ACT_LOAD_ROW) && layer_ok && row_ok;
	assign mat_waddr = AW'(cmd.round_index) * AW'(ROWS) + AW'(cmd.row_index);
	assign mat_wdata = {cmd.row_mask_y[WORD_BITS-1:0], cmd.row_mask_x[WORD_BITS-1:0]};

	assign cst_we    = cmd_accept && (cmd.action == wae_pkg::ACT_LOAD_CONST) && layer_ok;
	assign cst_waddr = LW'(cmd.round_index);
	assign cst_wdata = {cmd.const_y[WORD_BITS-1:0], cmd.const_x[WORD_BITS-1:0]};

	// Even steps read x row r, odd steps read y row WORD_BITS+r.
	assign row_off   = k_q[0] ? (KW'(WORD_BITS) + {1'b0, k_q[KW-1:1]})
	                          : {1'b0, k_q[KW-1:1]};
	assign mat_re    = (state_q == RUN);
	assign mat_raddr = base_q + AW'(row_off);
	assign cst_re    = (state_q == START);

	// The constant pair read in the start state is ready in the first row cycle,
	// the cycle before the first matrix row arrives.
	assign ctl.load_plain = cmd_accept && is_encrypt;
	assign ctl.swap       = (state_q == START) && (layer_q != '0);
	assign ctl.load_const = (state_q == RUN) && (k_q == '0);
	assign ctl.row_valid  = rd_vld_s1;
	assign ctl.row_is_y   = rd_half_s1;
	assign ctl.add_en     = (layer_q != LW'(ROUND_COUNT));

	// The result register is loaded once it is empty or being taken.
	assign load_out = (state_q == FINISH) && (!res_valid_q || !res_stall);

	wae_store #(
		.WORD_BITS   (WORD_BITS),
		.ROUND_COUNT (ROUND_COUNT)
	) u_store (
		.clk       (clk),
		.mat_we    (mat_we),
		.mat_waddr (mat_waddr),
		.mat_wdata (mat_wdata),
		.mat_re    (mat_re),
		.mat_raddr (mat_raddr),
		.mat_rdata (mat_rdata),
		.cst_we    (cst_we),
		.cst_waddr (cst_waddr),
		.cst_wdata (cst_wdata),
		.cst_re    (cst_re),
		.cst_raddr (layer_q),
		.cst_rdata (cst_rdata)
	);

	wae_serial #(
		.WORD_BITS (WORD_BITS)
	) u_serial (
		.clk        (clk),
		.ctl        (ctl),
		.plain_x    (cmd.plain_x[WORD_BITS-1:0]),
		.plain_y    (cmd.plain_y[WORD_BITS-1:0]),
		.row_data   (mat_rdata),
		.const_data (cst_rdata),
		.result_x   (result_x),
		.result_y   (result_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			layer_q     <= '0;
			base_q      <= '0;
			k_q         <= '0;
			rd_vld_s1   <= 1'b0;
			rd_half_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == RUN);
			rd_half_s1 <= k_q[0];
			if (res_valid_q && !res_stall && !load_out) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (cmd_accept && is_encrypt) begin
						layer_q <= '0;
						base_q  <= '0;
						state_q <= START;
					end
				end
				START: begin
					k_q     <= '0;
					state_q <= RUN;
				end
				RUN: begin
					k_q <= k_q + 1'b1;
					if (k_q == KW'(ROWS - 1)) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (layer_q == LW'(ROUND_COUNT)) begin
						state_q <= FINISH;
					end else begin
						layer_q <= layer_q + 1'b1;
						base_q  <= base_q + AW'(ROWS);
						state_q <= START;
					end
				end
				FINISH: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.cipher_x <= wae_pkg::FIELD_BITS'(result_x);
			res_q.cipher_y <= wae_pkg::FIELD_BITS'(result_y);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Neither store is written while an encrypt is reading the matrix.
	assert property (@(posedge clk) disable iff (!arst_n)
		mat_re |-> !mat_we && !cst_we)
		else $error("store written during an encrypt");

	// The constant load never coincides with a matrix row in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_const |-> !rd_vld_s1)
		else $error("constant load collides with a row");

	// The layer counter never passes the final layer.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != IDLE |-> layer_q <= LW'(ROUND_COUNT))
		else $error("layer counter out of range");

	// After a drain the sequencer starts another layer or finishes.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DRAIN |=> state_q == START || state_q == FINISH)
		else $error("bad state after drain");

	// A finished result lands in the output register without overwriting one.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> res_valid && state_q == IDLE)
		else $error("result not presented");

endmodule

/* dv/whitebox_affine_arx_encrypt_tb.sv */
module whitebox_affine_arx_encrypt_tb;

	// The block is built at its default size, and the scoreboard uses the same numbers.
	localparam int ROUND_COUNT = 34;
	localparam int WORD_BITS   = 64;
	localparam int LAYER_ROWS  = 2 * WORD_BITS;

	// Action code 3 has no meaning. The block must drop it without a result.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// One encrypt walks every row of every layer. ENC_LATENCY is the time from
	// acceptance to a valid result.
	localparam int ENC_LATENCY  = (ROUND_COUNT + 1) * (2 * WORD_BITS + 2) + 1;
	// The long receiver hold-off covers about three encrypts. The first ciphertext sits
	// in the output register while later encrypt requests back up at the input.
	localparam int HOLD_CYCLES  = 3 * ENC_LATENCY + 1000;
	localparam int RANDOM_ITEMS = 130;
	localparam int CLK_PERIOD   = 10;
	// The watchdog allows several times the slowest correct run: two full store fills at
	// the largest gaps, every random request an encrypt, the hold-off, and the drain.
	localparam longint WATCHDOG_TIME = 64'd4_000_000 * CLK_PERIOD;

	typedef logic [wae_pkg::FIELD_BITS-1:0] word_t;
	localparam word_t ZERO = '0;
	localparam word_t ONES = '1;

	// A row of the directed table. Where "typed" is set, the ciphertext is written
	// out by hand. Otherwise the scoreboard computes it.
	typedef struct {
		wae_pkg::cmd_t req;
		bit            typed;
		wae_pkg::res_t want;
	} dir_row_t;

	bit            clk = 1'b0;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_stall;
	wae_pkg::cmd_t cmd;
	logic          res_valid;
	logic          res_stall;
	wae_pkg::res_t res;

	// Scoreboard copy of the two stores: every matrix row as an (x mask, y mask)
	// pair, and one constant pair per affine layer.
	word_t mix_row_x   [0:ROUND_COUNT][0:LAYER_ROWS-1];
	word_t mix_row_y   [0:ROUND_COUNT][0:LAYER_ROWS-1];
	word_t layer_cst_x [0:ROUND_COUNT];
	word_t layer_cst_y [0:ROUND_COUNT];

	// Ciphertexts that are owed, oldest first.
	wae_pkg::res_t cipher_due_q[$];

	int  fail_count = 0;
	int  n_requests = 0;
	int  n_encrypts = 0;
	int  n_checked  = 0;
	int  send_burst = 0;
	int  recv_burst = 0;
	bit  hold_armed = 1'b0;

	whitebox_affine_arx_encrypt #(
		.ROUND_COUNT(ROUND_COUNT),
		.WORD_BITS  (WORD_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Scoreboard model
	// ------------------------------------------------------------------

	// One affine layer. Each new bit is the parity of the masked x and y words.
	// The rows in the lower half form x and the rows in the upper half form y.
	// The constant pair of the layer is XORed in last.
	function automatic void affine_mix(input int layer, inout word_t x, inout word_t y);
		word_t nx, ny;
		nx = ZERO;
		ny = ZERO;
		for (int r = 0; r < WORD_BITS; r++) begin
			nx[r] = ^((mix_row_x[layer][r] & x) ^ (mix_row_y[layer][r] & y));
			ny[r] = ^((mix_row_x[layer][WORD_BITS+r] & x) ^
				(mix_row_y[layer][WORD_BITS+r] & y));
		end
		x = nx ^ layer_cst_x[layer];
		y = ny ^ layer_cst_y[layer];
	endfunction

	// Applies one accepted request to the scoreboard stores. It returns 1 and the
	// ciphertext when the request is an encrypt. A load aimed past the last layer
	// is dropped, and so is the unused action code.
	function automatic bit predict_cipher(input wae_pkg::cmd_t c, output wae_pkg::res_t r);
		word_t x, y;
		r = '0;
		case (c.action)
			wae_pkg::ACT_LOAD_ROW: begin
				if (c.round_index <= ROUND_COUNT && c.row_index < LAYER_ROWS) begin
					mix_row_x[c.round_index][c.row_index] = c.row_mask_x;
					mix_row_y[c.round_index][c.row_index] = c.row_mask_y;
				end
				return 1'b0;
			end
			wae_pkg::ACT_LOAD_CONST: begin
				if (c.round_index <= ROUND_COUNT) begin
					layer_cst_x[c.round_index] = c.const_x;
					layer_cst_y[c.round_index] = c.const_y;
				end
				return 1'b0;
			end
			wae_pkg::ACT_ENCRYPT: begin
				x = c.plain_x;
				y = c.plain_y;
				// Each round is an affine layer and then x += y. The final layer
				// has no addition after it.
				for (int i = 0; i < ROUND_COUNT; i++) begin
					affine_mix(i, x, y);
					x = x + y;
				end
				affine_mix(ROUND_COUNT, x, y);
				r.cipher_x = x;
				r.cipher_y = y;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Request builders. Fields that a request does not use get random bits, so
	// that every bit of the payload toggles even where the block ignores it.
	// ------------------------------------------------------------------

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	// Biased toward the corner values: all zero, all ones, and a single set bit.
	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: return ZERO;
			1: return ONES;
			2: return word_t'(1) << $urandom_range(0, wae_pkg::FIELD_BITS - 1);
			default: return rand_word();
		endcase
	endfunction

	function automatic wae_pkg::cmd_t noise_req();
		wae_pkg::cmd_t c;
		c.action      = 2'($urandom);
		c.round_index = 6'($urandom);
		c.row_index   = 7'($urandom);
		c.row_mask_x  = rand_word();
		c.row_mask_y  = rand_word();
		c.const_x     = rand_word();
		c.const_y     = rand_word();
		c.plain_x     = rand_word();
		c.plain_y     = rand_word();
		return c;
	endfunction

	function automatic wae_pkg::cmd_t row_req(input int layer, input int row, input word_t mx,
		input word_t my);
		wae_pkg::cmd_t c;
		c             = noise_req();
		c.action      = wae_pkg::ACT_LOAD_ROW;
		c.round_index = 6'(layer);
		c.row_index   = 7'(row);
		c.row_mask_x  = mx;
		c.row_mask_y  = my;
		return c;
	endfunction

	function automatic wae_pkg::cmd_t const_req(input int layer, input word_t cx,
		input word_t cy);
		wae_pkg::cmd_t c;
		c             = noise_req();
		c.action      = wae_pkg::ACT_LOAD_CONST;
		c.round_index = 6'(layer);
		c.const_x     = cx;
		c.const_y     = cy;
		return c;
	endfunction

	function automatic wae_pkg::cmd_t enc_req(input word_t px, input word_t py);
		wae_pkg::cmd_t c;
		c         = noise_req();
		c.action  = wae_pkg::ACT_ENCRYPT;
		c.plain_x = px;
		c.plain_y = py;
		return c;
	endfunction

	// Wait before the next request or result, usually a random gap. Now and then a
	// burst of zero gaps keeps the channel busy every cycle.
	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0) begin
			burst = $urandom_range(8, 24);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offers one request and holds it until the block takes it. Valid is lowered
	// only when a gap follows. Back-to-back requests keep valid high, so valid
	// never gets two updates in one time step. The stall seen just after the edge
	// is the value from before the edge, which decides acceptance.
	task automatic send_request(input wae_pkg::cmd_t c, input bit typed,
		input wae_pkg::res_t want);
		int            gap;
		wae_pkg::res_t r;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		n_requests++;
		if (predict_cipher(c, r)) begin
			n_encrypts++;
			cipher_due_q.push_back(typed ? want : r);
		end
	endtask

	// Writes every matrix row and constant pair of every layer. The block must never
	// read an entry that was not written, so no encrypt comes before the first fill.
	// The scrambled fill mixes identity-like rows (a tap on the matching bit, with
	// some extra taps) with dense random rows and corner values.
	task automatic fill_stores(input bit scrambled);
		word_t mx, my;
		for (int layer = 0; layer <= ROUND_COUNT; layer++) begin
			for (int row = 0; row < LAYER_ROWS; row++) begin
				mx = ZERO;
				my = ZERO;
				if (scrambled) begin
					case ($urandom_range(0, 3))
						0, 1: begin
							if (row < WORD_BITS) mx = word_t'(1) << row;
							else my = word_t'(1) << (row - WORD_BITS);
							mx = mx ^ (($urandom_range(0, 1) == 1) ? pick_word() : ZERO);
							my = my ^ (($urandom_range(0, 1) == 1) ? pick_word() : ZERO);
						end
						2: begin
							mx = rand_word();
							my = rand_word();
						end
						default: begin
							mx = pick_word();
							my = pick_word();
						end
					endcase
				end
				send_request(row_req(layer, row, mx, my), 1'b0, '0);
			end
			send_request(const_req(layer, scrambled ? rand_word() : ZERO,
				scrambled ? rand_word() : ZERO), 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// The receiver draws a stall length for each result. When the stimulus asks
	// for the long hold-off, it keeps stall high for HOLD_CYCLES by its own count.
	// During that time the block finishes an encrypt, cannot hand it over, and has
	// to stall the requests still arriving.
	initial begin : result_drain
		int gap;
		res_stall = 1'b0;
		forever begin
			if (hold_armed) begin
				hold_armed = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = draw_gap(recv_burst);
				if (gap > 0) begin
					res_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid && !hold_armed) @(posedge clk);
		end
	end

	// Each ciphertext handed over is checked against the oldest one owed.
	always @(posedge clk) begin : result_check
		wae_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (cipher_due_q.size() == 0) begin
				$error("unexpected result: cipher_x %h cipher_y %h", res.cipher_x, res.cipher_y);
				fail_count++;
			end else begin
				want = cipher_due_q.pop_front();
				n_checked++;
				if (res.cipher_x !== want.cipher_x) begin
					$error("cipher_x mismatch: expected %h actual %h", want.cipher_x,
						res.cipher_x);
					fail_count++;
				end
				if (res.cipher_y !== want.cipher_y) begin
					$error("cipher_y mismatch: expected %h actual %h", want.cipher_y,
						res.cipher_y);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	initial begin : stimulus
		dir_row_t      dir_tab[$];
		wae_pkg::cmd_t c;
		int            roll;

		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start from a known all-zero image. With every matrix row zero, each layer
		// returns just its constant pair, so the ciphertext can be read off directly.
		fill_stores(1'b0);

		// Directed requests.
		// Zero matrices and zero constants give a zero ciphertext at both plaintext
		// extremes.
		dir_tab.push_back('{enc_req(ZERO, ZERO), 1'b1, {ZERO, ZERO}});
		dir_tab.push_back('{enc_req(ONES, ONES), 1'b1, {ZERO, ZERO}});
		// The constant of the final layer comes straight through.
		dir_tab.push_back('{const_req(ROUND_COUNT, ONES, ONES), 1'b0, '0});
		dir_tab.push_back('{enc_req(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210), 1'b1,
			{ONES, ONES}});
		// Loads aimed past the last layer, up to the top of the field, and the unused
		// action code with every bit set. All of them must leave the stores alone.
		dir_tab.push_back('{const_req(ROUND_COUNT + 1, ZERO, ZERO), 1'b0, '0});
		dir_tab.push_back('{const_req(63, ZERO, ZERO), 1'b0, '0});
		dir_tab.push_back('{row_req(63, 0, ONES, ONES), 1'b0, '0});
		dir_tab.push_back('{row_req(ROUND_COUNT + 1, LAYER_ROWS - 1, ONES, ONES), 1'b0, '0});
		dir_tab.push_back('{wae_pkg::cmd_t'('1), 1'b0, '0});
		dir_tab.push_back('{enc_req(ONES, ZERO), 1'b1, {ONES, ONES}});
		// Layer 33 leaves x = 1 and y = 0, and the add keeps x = 1. Row 0 of the final
		// layer taps x bit 0, which clears bit 0 of the final x.
		dir_tab.push_back('{const_req(ROUND_COUNT - 1, 64'h1, ZERO), 1'b0, '0});
		dir_tab.push_back('{row_req(ROUND_COUNT, 0, 64'h1, ZERO), 1'b0, '0});
		dir_tab.push_back('{enc_req(ZERO, ZERO), 1'b1, {64'hffff_ffff_ffff_fffe, ONES}});
		// The last row, with full masks on both words, drives the top bit of y.
		dir_tab.push_back('{row_req(ROUND_COUNT, LAYER_ROWS - 1, ONES, ONES), 1'b0, '0});
		dir_tab.push_back('{enc_req(ONES, ONES), 1'b0, '0});
		// Give the first layer a plaintext dependence, then clear the last constant.
		dir_tab.push_back('{row_req(0, WORD_BITS, ZERO, ONES), 1'b0, '0});
		dir_tab.push_back('{row_req(0, 0, ONES, ZERO), 1'b0, '0});
		dir_tab.push_back('{const_req(0, ONES, ZERO), 1'b0, '0});
		dir_tab.push_back('{enc_req(64'h5, 64'h3), 1'b0, '0});
		dir_tab.push_back('{enc_req(ONES, ONES), 1'b0, '0});
		dir_tab.push_back('{const_req(ROUND_COUNT, ZERO, ZERO), 1'b0, '0});
		dir_tab.push_back('{enc_req(64'h8000_0000_0000_0000, 64'h1), 1'b0, '0});

		foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

		// Reload the whole image with mixed content so the rounds really diffuse.
		fill_stores(1'b1);

		// Random requests. Most of them are encrypts or valid loads into the image.
		// The rest are dropped loads and the unused code. Partway through, the
		// receiver starts the long hold-off while requests keep coming.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) hold_armed = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				c = enc_req(pick_word(), pick_word());
			end else if (roll < 70) begin
				c = row_req($urandom_range(0, ROUND_COUNT), $urandom_range(0, LAYER_ROWS - 1),
					pick_word(), pick_word());
			end else if (roll < 85) begin
				c = const_req($urandom_range(0, ROUND_COUNT), pick_word(), pick_word());
			end else begin
				c = noise_req();
				if (roll < 92) begin
					c.action = ACT_UNUSED;
				end else begin
					c.action      = (roll < 96) ? wae_pkg::ACT_LOAD_ROW
					                            : wae_pkg::ACT_LOAD_CONST;
					c.round_index = 6'($urandom_range(ROUND_COUNT + 1, 63));
				end
			end
			send_request(c, 1'b0, '0);
		end
		cmd_valid <= 1'b0;

		// Let every owed ciphertext arrive. Then wait one more encrypt time to catch
		// anything the block sends that was not asked for.
		while (cipher_due_q.size() != 0) @(posedge clk);
		repeat (ENC_LATENCY + 16) @(posedge clk);

		$display("Run covered %0d requests: two full store fills, directed corners, dropped loads,",
			n_requests);
		$display("random traffic and a long output hold-off; %0d of %0d ciphertexts checked.",
			n_checked, n_encrypts);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog for a hung handshake or a ciphertext that never arrives.
	initial begin : watchdog
		#(WATCHDOG_TIME);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
